@@ rtl/pnt_pkg.sv @@
// Package for the perfect number test block.
// Holds the shared width constants; no dependencies.
package pnt_pkg;

    // Default width of the tested number, two's complement.
    localparam int WIDTH_DEFAULT = 32;

    // Width of the divisor sum delivered on the result channel.
    localparam int SUM_WIDTH = 34;

endpackage : pnt_pkg

@@ rtl/pnt_in_if.sv @@
// Input channel of the perfect number test block: valid, ready and the number.
// Depends on nothing but its WIDTH parameter.
interface pnt_in_if #(
    parameter int WIDTH = 32
);
    logic                    valid;
    logic                    ready;
    logic signed [WIDTH-1:0] number;

    modport source (output valid, output number, input ready);
    modport sink (input valid, input number, output ready);
endinterface : pnt_in_if

@@ rtl/pnt_out_if.sv @@
// Result channel of the perfect number test block: valid, ready, sum and flag.
// Depends on pnt_pkg for the sum width.
interface pnt_out_if;
    import pnt_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [SUM_WIDTH-1:0] divisor_sum;
    logic                 is_perfect;

    modport source (output valid, output divisor_sum, output is_perfect, input ready);
    modport sink (input valid, input divisor_sum, input is_perfect, output ready);
endinterface : pnt_out_if

@@ rtl/perfect_number_test.sv @@
// Perfect number test: sums the proper divisors of a number by trial division.
// Depends on pnt_pkg, pnt_in_if and pnt_out_if.
//
// Usage. A number enters on the req channel; one transaction carries one signed
// value of WIDTH bits. Exactly one result leaves on the rsp channel: the sum of
// the proper divisors (34 bits, wrapping if it were ever wider) and a flag that
// is set when that sum equals the number. Negative numbers, zero and one give
// a sum of zero and a clear flag.
// Sequence. Trial divisors i = 2, 3, ... are tried while i <= n / i. Each
// trial runs the shared restoring divider, one quotient bit per cycle, then
// a check state, and an add-cofactor state when a cofactor is added. The
// block handles one number at a time; req.ready is high only while the
// sequencer is idle.
// Stalls. The result sits in an output register. While the receiver holds
// rsp.ready low, the block still accepts and works on the next number; only its
// final hand-over waits until the output register is free.
// Reset. rst_n clears the sequencer and the output valid flag at once; no
// item in flight survives it and the block keeps no other state.
module perfect_number_test #(
    parameter int WIDTH = pnt_pkg::WIDTH_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    pnt_in_if.sink     req,
    pnt_out_if.source  rsp
);
    import pnt_pkg::*;

    // Magnitude bits of a non-negative number.
    localparam int NW = WIDTH - 1;
    // Trial divisors never exceed sqrt(n) + 1.
    localparam int IW = (NW + 1) / 2 + 1;
    localparam int CW = $clog2(NW + 1);
    // Sigma(n) stays below 8n for the whole parameter range.
    localparam int SW = (NW + 3 > SUM_WIDTH) ? NW + 3 : SUM_WIDTH;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_CHECK,
        ST_ADD_CO,
        ST_FINISH
    } state_t;

    state_t               state_reg,     state_next;
    logic [NW-1:0]        n_reg,         n_next;
    logic [IW-1:0]        i_reg,         i_next;
    logic [IW-1:0]        rem_reg,       rem_next;
    logic [NW-1:0]        quo_reg,       quo_next;
    logic [CW-1:0]        cnt_reg,       cnt_next;
    logic [SW-1:0]        total_reg,     total_next;
    logic                 out_valid_reg, out_valid_next;
    logic [SUM_WIDTH-1:0] out_sum_reg,   out_sum_next;
    logic                 out_perf_reg,  out_perf_next;

    logic [IW:0]          trial;
    logic [IW:0]          diff;
    logic                 trial_ge;
    logic [NW-1:0]        i_ext;
    logic [NW-1:0]        addend;
    logic [SW-1:0]        sum;
    logic                 out_free;

    // Restoring divider step: bring down the next dividend bit and try to
    // subtract the current trial divisor.
    assign trial    = {rem_reg, quo_reg[NW-1]};
    assign diff     = trial - {1'b0, i_reg};
    assign trial_ge = (trial >= {1'b0, i_reg});

    assign i_ext    = {{(NW-IW){1'b0}}, i_reg};

    // One adder serves both the divisor and the cofactor accumulation.
    assign addend   = (state_reg == ST_CHECK) ? i_ext : quo_reg;
    assign sum      = total_reg + {{(SW-NW){1'b0}}, addend};

    assign out_free = !out_valid_reg || rsp.ready;

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        i_next         = i_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        total_next     = total_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_sum_next   = out_sum_reg;
        out_perf_next  = out_perf_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    if (!req.number[WIDTH-1] && (req.number[NW-1:0] >= NW'(2)))
                    begin
                        n_next     = req.number[NW-1:0];
                        total_next = SW'(1);
                        i_next     = IW'(2);
                        rem_next   = '0;
                        quo_next   = req.number[NW-1:0];
                        cnt_next   = CW'(NW);
                        state_next = ST_DIVIDE;
                    end
                    else
                    begin
                        n_next     = '0;
                        total_next = '0;
                        state_next = ST_FINISH;
                    end
                end
            end

            ST_DIVIDE:
            begin
                rem_next = trial_ge ? diff[IW-1:0] : trial[IW-1:0];
                quo_next = {quo_reg[NW-2:0], trial_ge};
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    state_next = ST_CHECK;
                end
            end

            ST_CHECK:
            begin
                // The search ends once the divisor passes the quotient.
                if (i_ext > quo_reg)
                begin
                    state_next = ST_FINISH;
                end
                else if (rem_reg == '0)
                begin
                    total_next = sum;
                    if (quo_reg != i_ext)
                    begin
                        state_next = ST_ADD_CO;
                    end
                    else
                    begin
                        i_next     = i_reg + IW'(1);
                        rem_next   = '0;
                        quo_next   = n_reg;
                        cnt_next   = CW'(NW);
                        state_next = ST_DIVIDE;
                    end
                end
                else
                begin
                    i_next     = i_reg + IW'(1);
                    rem_next   = '0;
                    quo_next   = n_reg;
                    cnt_next   = CW'(NW);
                    state_next = ST_DIVIDE;
                end
            end

            ST_ADD_CO:
            begin
                total_next = sum;
                i_next     = i_reg + IW'(1);
                rem_next   = '0;
                quo_next   = n_reg;
                cnt_next   = CW'(NW);
                state_next = ST_DIVIDE;
            end

            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_sum_next   = total_reg[SUM_WIDTH-1:0];
                    // A zero sum marks an input below two, which is never perfect.
                    out_perf_next  = (total_reg == {{(SW-NW){1'b0}}, n_reg}) &&
                                     (total_reg != '0);
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            n_reg         <= '0;
            i_reg         <= '0;
            rem_reg       <= '0;
            quo_reg       <= '0;
            cnt_reg       <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_sum_reg   <= '0;
            out_perf_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            i_reg         <= i_next;
            rem_reg       <= rem_next;
            quo_reg       <= quo_next;
            cnt_reg       <= cnt_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
            out_sum_reg   <= out_sum_next;
            out_perf_reg  <= out_perf_next;
        end
    end

    assign req.ready       = (state_reg == ST_IDLE);
    assign rsp.valid       = out_valid_reg;
    assign rsp.divisor_sum = out_sum_reg;
    assign rsp.is_perfect  = out_perf_reg;

endmodule : perfect_number_test
